// ===== hdl/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Types and constants shared by the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

	// operation codes of a command item
	localparam logic [2:0] OP_LOAD_A   = 3'd0;
	localparam logic [2:0] OP_LOAD_B   = 3'd1;
	localparam logic [2:0] OP_LOAD_OUT = 3'd2;
	localparam logic [2:0] OP_RUN      = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 2'd2;
	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 5'd16;

	// saturation bounds of an output entry
	localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

	typedef struct packed {
		logic [2:0]         op;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [39:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [39:0] data;
		logic               saturated;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

// ===== hdl/matrix_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Matrix multiply-accumulate, out += A * B, over three on-chip memories.
// ----------------------------------------------------------------------------
// cmd_valid / cmd_ready / cmd take one item per op: load an A, B or output
//   element, run out += A*B, or read an output element
// rsp_valid / rsp_ready / rsp return one item per command, in order; data is
//   the read value (zero for the other ops), saturated is set when the last
//   run clipped any output entry
// cfg_we / cfg_index / cfg_data set the dimensions while idle; values above
//   MAX_DIM act as MAX_DIM, zero makes a run a no-op
// loads: one item per cycle while no response stalls, response registered
//   in the cycle after accept; reads: no new command in ST_READ, which
//   holds the registered output memory read
// run: one product per cycle, out_rows * out_cols * inner_len of them, then
//   ST_DRAIN empties the multiply / accumulate pipe and loads the response
// reset: dimensions return to 16 and the clip flag clears; memory contents
//   are undefined until written
// stall: a response waits in its output register; the next command is taken
//   in the same cycle the waiting response leaves, never while it is stuck
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
	parameter int MAX_DIM = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  mma_pkg::cmd_t                    cmd,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output mma_pkg::rsp_t                    rsp
);

	localparam int Depth = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(Depth);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int CW    = (DW > mma_pkg::CFG_DATA_W) ? DW : mma_pkg::CFG_DATA_W;
	localparam logic [AW-1:0] Stride = AW'(MAX_DIM);

	// dimension registers
	logic [mma_pkg::CFG_DATA_W-1:0] rows_q, inner_q, cols_q;
	logic [DW-1:0] dim_rows, dim_inner, dim_cols;
	logic          dim_zero;

	// state memories
	logic [15:0] mem_a   [Depth];
	logic [15:0] mem_b   [Depth];
	logic [39:0] mem_out [Depth];

	logic signed [15:0] a_rdata, b_rdata;
	logic signed [39:0] out_rdata;

	// control
	mma_pkg::state_t state_q, state_d;
	logic accept, issue, rsp_load, clip_clr, pipe_empty;
	mma_pkg::rsp_t rsp_d;

	logic cmd_inside, inside_q;
	logic [AW-1:0] cmd_addr;

	// loop counters
	logic [IW-1:0] i_q, j_q, k_q;
	logic last_i, last_j, last_k, last_all;
	logic [AW-1:0] a_raddr, b_raddr, out_addr_run, out_raddr;

	// mac pipeline
	logic              valid_s1, last_s1, first_s1;
	logic [AW-1:0]     waddr_s1;
	logic              valid_s2, last_s2;
	logic signed [31:0] prod_s2;
	logic [AW-1:0]     waddr_s2;
	logic signed [39:0] acc_q;
	logic signed [40:0] sum;
	logic signed [39:0] sum_sat;
	logic              sum_ovf;
	logic              clip_q;

	// write ports
	logic          wb_en;
	logic          out_we;
	logic [AW-1:0] out_waddr;
	logic [39:0]   out_wdata;

	// dimensions clipped to the array size
	always_comb begin
		dim_rows  = (CW'(rows_q)  > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rows_q);
		dim_inner = (CW'(inner_q) > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(inner_q);
		dim_cols  = (CW'(cols_q)  > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_q);
		dim_zero  = (dim_rows == '0) || (dim_inner == '0) || (dim_cols == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= mma_pkg::DIM_RESET;
			inner_q <= mma_pkg::DIM_RESET;
			cols_q  <= mma_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mma_pkg::CFG_OUT_ROWS:  rows_q  <= cfg_data;
				mma_pkg::CFG_INNER_LEN: inner_q <= cfg_data;
				mma_pkg::CFG_OUT_COLS:  cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// command addressing, element (r,c) at r*MAX_DIM+c
	assign cmd_inside = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);
	assign cmd_addr   = AW'(cmd.row) * Stride + AW'(cmd.col);

	assign accept = cmd_valid && cmd_ready;

	// loop position
	always_comb begin
		last_i       = (DW'(i_q) == dim_rows  - DW'(1));
		last_j       = (DW'(j_q) == dim_cols  - DW'(1));
		last_k       = (DW'(k_q) == dim_inner - DW'(1));
		last_all     = last_i && last_j && last_k;
		a_raddr      = AW'(i_q) * Stride + AW'(k_q);
		b_raddr      = AW'(k_q) * Stride + AW'(j_q);
		out_addr_run = AW'(i_q) * Stride + AW'(j_q);
		out_raddr    = (state_q == mma_pkg::ST_RUN) ? out_addr_run : cmd_addr;
	end

	assign pipe_empty = !valid_s1 && !valid_s2;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mma_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.op == mma_pkg::OP_RUN && !dim_zero) begin
						state_d = mma_pkg::ST_RUN;
					end else if (cmd.op == mma_pkg::OP_READ) begin
						state_d = mma_pkg::ST_READ;
					end
				end
			end
			mma_pkg::ST_READ:  state_d = mma_pkg::ST_IDLE;
			mma_pkg::ST_RUN: begin
				if (last_all) state_d = mma_pkg::ST_DRAIN;
			end
			mma_pkg::ST_DRAIN: begin
				if (pipe_empty) state_d = mma_pkg::ST_IDLE;
			end
			default: state_d = mma_pkg::ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		cmd_ready = 1'b0;
		issue     = 1'b0;
		rsp_load  = 1'b0;
		clip_clr  = 1'b0;
		rsp_d     = '0;
		case (state_q)
			mma_pkg::ST_IDLE: begin
				cmd_ready = !rsp_valid || rsp_ready;
				if (cmd_valid && cmd_ready) begin
					clip_clr = (cmd.op == mma_pkg::OP_RUN);
					// loads, unknown ops and empty runs answer at once
					rsp_load = (cmd.op != mma_pkg::OP_READ) &&
						!(cmd.op == mma_pkg::OP_RUN && !dim_zero);
					rsp_d.saturated = (cmd.op == mma_pkg::OP_RUN) ? 1'b0 : clip_q;
				end
			end
			mma_pkg::ST_READ: begin
				rsp_load        = 1'b1;
				rsp_d.data      = inside_q ? out_rdata : '0;
				rsp_d.saturated = clip_q;
			end
			mma_pkg::ST_RUN: begin
				issue = 1'b1;
			end
			mma_pkg::ST_DRAIN: begin
				rsp_load        = pipe_empty;
				rsp_d.saturated = clip_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) inside_q <= cmd_inside;
	end

	// loop counters, k innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (accept) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			if (last_k) begin
				k_q <= '0;
				if (last_j) begin
					j_q <= '0;
					i_q <= i_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end else begin
				k_q <= k_q + IW'(1);
			end
		end
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (accept && cmd_inside && cmd.op == mma_pkg::OP_LOAD_A) begin
			mem_a[cmd_addr] <= cmd.value[15:0];
		end
		a_rdata <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd_inside && cmd.op == mma_pkg::OP_LOAD_B) begin
			mem_b[cmd_addr] <= cmd.value[15:0];
		end
		b_rdata <= mem_b[b_raddr];
	end

	// accumulate write-back has the port during a run, commands otherwise
	assign wb_en = valid_s2 && last_s2;
	always_comb begin
		if (wb_en) begin
			out_we    = 1'b1;
			out_waddr = waddr_s2;
			out_wdata = sum_sat;
		end else begin
			out_we    = accept && cmd_inside && cmd.op == mma_pkg::OP_LOAD_OUT;
			out_waddr = cmd_addr;
			out_wdata = cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) mem_out[out_waddr] <= out_wdata;
		out_rdata <= mem_out[out_raddr];
	end

	// stage 1: operands arrive, stage 2: product registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= last_k;
		first_s1 <= (k_q == '0);
		waddr_s1 <= out_addr_run;
		last_s2  <= last_s1;
		waddr_s2 <= waddr_s1;
		prod_s2  <= a_rdata * b_rdata;
	end

	// saturating accumulate; entries differ, so a new entry's seed may
	// overwrite acc in the cycle the previous entry writes back
	always_comb begin
		sum     = 41'(acc_q) + 41'(prod_s2);
		sum_ovf = sum[40] != sum[39];
		if (sum_ovf) begin
			sum_sat = sum[40] ? mma_pkg::ACC_MIN : mma_pkg::ACC_MAX;
		end else begin
			sum_sat = sum[39:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && first_s1) begin
			acc_q <= out_rdata;
		end else if (valid_s2) begin
			acc_q <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (clip_clr) begin
			clip_q <= 1'b0;
		end else if (valid_s2 && sum_ovf) begin
			clip_q <= 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp <= rsp_d;
	end

endmodule

// ===== dv/matrix_multiply_accumulate_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_tb
// Self-checking bench for the matrix multiply-accumulate block. A short table
// of directed items covers extreme values, clipping at both bounds, wrapping
// of wide A/B values, unused op codes and empty dimensions. Random phases
// follow, each at its own set of dimensions. Every response is checked
// against its typed expectation or a bit-exact model of out += A*B held in
// the bench, with random stalls on both channels.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = 16;
	localparam int CELLS = DIM * DIM;
	localparam int LIMIT = 2000000;

	// op codes the block ignores
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index = mma_pkg::CFG_OUT_ROWS;
	logic [mma_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           cmd_valid = 1'b0;
	logic                           cmd_ready;
	mma_pkg::cmd_t                  cmd = '0;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b0;
	mma_pkg::rsp_t                  rsp;

	matrix_multiply_accumulate #(
		.MAX_DIM(DIM)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// model state: memories, clip flag and dimension registers
	// ------------------------------------------------------------------
	logic signed [15:0] a_mem [CELLS];
	logic signed [15:0] b_mem [CELLS];
	logic signed [39:0] o_mem [CELLS];
	logic               clip = 1'b0;
	logic [4:0]         dim_rows = mma_pkg::DIM_RESET;
	logic [4:0]         dim_inner = mma_pkg::DIM_RESET;
	logic [4:0]         dim_cols = mma_pkg::DIM_RESET;

	// which entries the bench has written, so nothing undefined is ever used
	bit a_wr [CELLS];
	bit b_wr [CELLS];
	bit o_wr [CELLS];

	// responses still owed by the block, oldest first
	mma_pkg::rsp_t rsp_due [$];

	// a directed item may carry its expected response typed in
	logic cmd_typed = 1'b0;
	mma_pkg::rsp_t cmd_typed_rsp = '0;

	bit idle_on = 1'b1;
	int items_sent = 0;
	int rsp_seen = 0;
	int errors = 0;
	int n_runs = 0;
	int n_clipped = 0;
	int n_reads = 0;
	int n_settings = 0;
	int cycles = 0;
	int stall_left = 0;

	function automatic int eff_dim(input logic [4:0] d);
		return (d > DIM) ? DIM : int'(d);
	endfunction

	// apply one command to the model state and return its response
	function automatic mma_pkg::rsp_t mma_apply(input mma_pkg::cmd_t c);
		mma_pkg::rsp_t r;
		int     idx;
		int     nr;
		int     nk;
		int     nc;
		longint acc;
		r.data = '0;
		idx = int'(c.row) * DIM + int'(c.col);
		case (c.op)
			mma_pkg::OP_LOAD_A: a_mem[idx] = c.value[15:0];
			mma_pkg::OP_LOAD_B: b_mem[idx] = c.value[15:0];
			mma_pkg::OP_LOAD_OUT: o_mem[idx] = c.value;
			mma_pkg::OP_RUN: begin
				nr = eff_dim(dim_rows);
				nk = eff_dim(dim_inner);
				nc = eff_dim(dim_cols);
				clip = 1'b0;
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = longint'(o_mem[i * DIM + j]);
						// ascending k, clip after every addition
						for (int k = 0; k < nk; k++) begin
							acc += longint'(a_mem[i * DIM + k]) *
								longint'(b_mem[k * DIM + j]);
							if (acc > longint'(mma_pkg::ACC_MAX)) begin
								acc = longint'(mma_pkg::ACC_MAX);
								clip = 1'b1;
							end
							if (acc < longint'(mma_pkg::ACC_MIN)) begin
								acc = longint'(mma_pkg::ACC_MIN);
								clip = 1'b1;
							end
						end
						o_mem[i * DIM + j] = acc[39:0];
					end
				end
			end
			mma_pkg::OP_READ: r.data = o_mem[idx];
			default: ;
		endcase
		r.saturated = clip;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// response side: random stall bursts on rsp_ready
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17);
		end
		rsp_ready <= (stall_left == 0);
	end

	// ------------------------------------------------------------------
	// monitor: check accepted responses, then model accepted commands
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		mma_pkg::rsp_t want;
		mma_pkg::rsp_t got_model;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (rsp_due.size() == 0) begin
				errors++;
				$display("%0t: response with none outstanding, expected none, actual %h/%b",
					$time, rsp.data, rsp.saturated);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.data !== want.data) begin
					errors++;
					$display("%0t: data mismatch, expected %h, actual %h",
						$time, want.data, rsp.data);
				end
				if (rsp.saturated !== want.saturated) begin
					errors++;
					$display("%0t: saturated mismatch, expected %b, actual %b",
						$time, want.saturated, rsp.saturated);
				end
			end
		end
		if (arst_n && cmd_valid && cmd_ready) begin
			got_model = mma_apply(cmd);
			if (cmd.op == mma_pkg::OP_RUN) begin
				n_runs++;
				if (got_model.saturated)
					n_clipped++;
			end
			if (cmd.op == mma_pkg::OP_READ)
				n_reads++;
			// typed expectation wins, the model state still advances
			rsp_due.push_back(cmd_typed ? cmd_typed_rsp : got_model);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: watchdog expired with %0d responses outstanding",
				$time, rsp_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// driver helpers
	// ------------------------------------------------------------------
	function automatic logic [39:0] rand40();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[39:0];
	endfunction

	// A/B element: full-range bits, Q8.8 extremes and small values
	function automatic logic [39:0] elem_value();
		logic [39:0] v;
		v = rand40();
		case ($urandom_range(0, 7))
			0: v[15:0] = 16'h7fff;
			1: v[15:0] = 16'h8000;
			2: v[15:8] = {8{v[7]}};
			default: ;
		endcase
		return v;
	endfunction

	// output entry: near either bound often, so runs clip
	function automatic logic [39:0] acc_value();
		logic [39:0] v;
		v = rand40();
		case ($urandom_range(0, 7))
			0: v = mma_pkg::ACC_MAX - {19'd0, v[20:0]};
			1: v = mma_pkg::ACC_MIN + {19'd0, v[20:0]};
			2: v = {{20{v[19]}}, v[19:0]};
			default: ;
		endcase
		return v;
	endfunction

	// present one item, hold it until accepted
	task automatic send_item(input mma_pkg::cmd_t c, input bit typed,
		input mma_pkg::rsp_t typed_rsp);
		int idx;
		idx = int'(c.row) * DIM + int'(c.col);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		cmd_typed <= typed;
		cmd_typed_rsp <= typed_rsp;
		case (c.op)
			mma_pkg::OP_LOAD_A: a_wr[idx] = 1'b1;
			mma_pkg::OP_LOAD_B: b_wr[idx] = 1'b1;
			mma_pkg::OP_LOAD_OUT: o_wr[idx] = 1'b1;
			default: ;
		endcase
		do begin
			@(posedge clk);
		end while (!cmd_ready);
		items_sent++;
	endtask

	// stop sending until every owed response is back
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (rsp_seen != items_sent);
	endtask

	task automatic set_dims(input logic [4:0] r, input logic [4:0] k, input logic [4:0] c);
		cfg_we <= 1'b1;
		cfg_index <= mma_pkg::CFG_OUT_ROWS;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= mma_pkg::CFG_INNER_LEN;
		cfg_data <= k;
		@(posedge clk);
		cfg_index <= mma_pkg::CFG_OUT_COLS;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_rows = r;
		dim_inner = k;
		dim_cols = c;
		n_settings++;
	endtask

	// load every entry a run at the current dimensions touches; some entries
	// that already hold data get fresh content too
	task automatic fill_region();
		int   nr;
		int   nk;
		int   nc;
		mma_pkg::cmd_t c;
		nr = eff_dim(dim_rows);
		nk = eff_dim(dim_inner);
		nc = eff_dim(dim_cols);
		for (int i = 0; i < nr; i++) begin
			for (int k = 0; k < nk; k++) begin
				if (!a_wr[i * DIM + k] || $urandom_range(0, 2) == 0) begin
					c = '{op: mma_pkg::OP_LOAD_A, row: 4'(i), col: 4'(k),
						value: elem_value()};
					send_item(c, 1'b0, '0);
				end
			end
		end
		for (int k = 0; k < nk; k++) begin
			for (int j = 0; j < nc; j++) begin
				if (!b_wr[k * DIM + j] || $urandom_range(0, 2) == 0) begin
					c = '{op: mma_pkg::OP_LOAD_B, row: 4'(k), col: 4'(j),
						value: elem_value()};
					send_item(c, 1'b0, '0);
				end
			end
		end
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				if (!o_wr[i * DIM + j] || $urandom_range(0, 2) == 0) begin
					c = '{op: mma_pkg::OP_LOAD_OUT, row: 4'(i), col: 4'(j),
						value: acc_value()};
					send_item(c, 1'b0, '0);
				end
			end
		end
	endtask

	// one random item; the region is loaded, so runs and reads are legal
	task automatic random_item();
		int   nr;
		int   nk;
		int   nc;
		int   pick;
		bit   in_reg;
		mma_pkg::cmd_t c;
		nr = eff_dim(dim_rows);
		nk = eff_dim(dim_inner);
		nc = eff_dim(dim_cols);
		pick = $urandom_range(0, 99);
		in_reg = ($urandom_range(0, 1) == 1);
		c.row = 4'($urandom_range(0, DIM - 1));
		c.col = 4'($urandom_range(0, DIM - 1));
		c.value = rand40();
		// long runs stay rare
		if (pick >= 60 && pick < 68 && nr * nk * nc > 512 && $urandom_range(0, 3) != 0)
			pick = 70;
		if (pick < 25) begin
			c.op = mma_pkg::OP_LOAD_A;
			c.value = elem_value();
			if (in_reg && nr > 0 && nk > 0) begin
				c.row = 4'($urandom_range(0, nr - 1));
				c.col = 4'($urandom_range(0, nk - 1));
			end
		end else if (pick < 40) begin
			c.op = mma_pkg::OP_LOAD_B;
			c.value = elem_value();
			if (in_reg && nk > 0 && nc > 0) begin
				c.row = 4'($urandom_range(0, nk - 1));
				c.col = 4'($urandom_range(0, nc - 1));
			end
		end else if (pick < 60) begin
			c.op = mma_pkg::OP_LOAD_OUT;
			c.value = acc_value();
			if (in_reg && nr > 0 && nc > 0) begin
				c.row = 4'($urandom_range(0, nr - 1));
				c.col = 4'($urandom_range(0, nc - 1));
			end
		end else if (pick < 68) begin
			c.op = mma_pkg::OP_RUN;
		end else if (pick < 95) begin
			c.op = mma_pkg::OP_READ;
			// only entries that hold data; the origin was loaded early on
			if (!o_wr[int'(c.row) * DIM + int'(c.col)]) begin
				if (nr > 0 && nc > 0) begin
					c.row = 4'($urandom_range(0, nr - 1));
					c.col = 4'($urandom_range(0, nc - 1));
				end else begin
					c.row = '0;
					c.col = '0;
				end
			end
		end else begin
			c.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end
		send_item(c, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	typedef struct {
		bit            dims_row;
		logic [4:0]    d_rows;
		logic [4:0]    d_inner;
		logic [4:0]    d_cols;
		mma_pkg::cmd_t c;
		bit            typed;
		mma_pkg::rsp_t r;
	} dir_row_t;

	dir_row_t dir_tab [$];

	function automatic void add_op(input logic [2:0] op, input logic [3:0] row,
		input logic [3:0] col, input logic [39:0] value, input bit typed,
		input logic [39:0] data, input logic sat);
		dir_row_t t;
		t.dims_row = 1'b0;
		t.d_rows = '0;
		t.d_inner = '0;
		t.d_cols = '0;
		t.c = '{op: op, row: row, col: col, value: value};
		t.typed = typed;
		t.r = '{data: data, saturated: sat};
		dir_tab.push_back(t);
	endfunction

	function automatic void add_dims(input logic [4:0] r, input logic [4:0] k,
		input logic [4:0] c);
		dir_row_t t;
		t.dims_row = 1'b1;
		t.d_rows = r;
		t.d_inner = k;
		t.d_cols = c;
		t.c = '0;
		t.typed = 1'b0;
		t.r = '0;
		dir_tab.push_back(t);
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stim
		int ph_cfg [9][3];
		int n_items;
		int pause_at;

		ph_cfg = '{'{3, 2, 4}, '{16, 3, 2}, '{0, 5, 3}, '{31, 1, 3},
			'{4, 0, 4}, '{1, 16, 1}, '{5, 3, 0}, '{2, 2, 17}, '{7, 9, 5}};

		// unused op straight after reset: no data, clip flag clear
		add_op(OP_UNUSED_HI, 4'hf, 4'hf, '1, 1'b1, '0, 1'b0);
		add_dims(5'd1, 5'd1, 5'd1);
		add_op(mma_pkg::OP_LOAD_OUT, 4'h0, 4'h0, mma_pkg::ACC_MAX, 1'b1, '0, 1'b0);
		add_op(mma_pkg::OP_READ, 4'h0, 4'h0, '0, 1'b1, mma_pkg::ACC_MAX, 1'b0);
		add_op(mma_pkg::OP_LOAD_A, 4'h0, 4'h0, 40'h00_0000_7fff, 1'b1, '0, 1'b0);
		add_op(mma_pkg::OP_LOAD_B, 4'h0, 4'h0, 40'h00_0000_7fff, 1'b1, '0, 1'b0);
		// positive product on top of the upper bound clips
		add_op(mma_pkg::OP_RUN, 4'h0, 4'h0, '0, 1'b1, '0, 1'b1);
		add_op(mma_pkg::OP_READ, 4'h0, 4'h0, '0, 1'b1, mma_pkg::ACC_MAX, 1'b1);
		add_op(mma_pkg::OP_LOAD_OUT, 4'h0, 4'h0, mma_pkg::ACC_MIN, 1'b1, '0, 1'b1);
		// upper bits of a wide A value are dropped, leaving -128.0
		add_op(mma_pkg::OP_LOAD_A, 4'h0, 4'h0, 40'h12_3456_8000, 1'b1, '0, 1'b1);
		add_op(mma_pkg::OP_RUN, 4'h0, 4'h0, '0, 1'b1, '0, 1'b1);
		add_op(mma_pkg::OP_READ, 4'h0, 4'h0, '0, 1'b1, mma_pkg::ACC_MIN, 1'b1);
		add_op(mma_pkg::OP_LOAD_OUT, 4'h0, 4'h0, '0, 1'b1, '0, 1'b1);
		add_op(mma_pkg::OP_RUN, 4'h0, 4'h0, '0, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_READ, 4'h0, 4'h0, '0, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_LOAD_B, 4'h0, 4'h0, 40'hff_ffff_8000, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_RUN, 4'h0, 4'h0, '0, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_READ, 4'h0, 4'h0, '0, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_LOAD_OUT, 4'h0, 4'h0, mma_pkg::ACC_MAX, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_RUN, 4'h0, 4'h0, '0, 1'b0, '0, 1'b0);
		// zero rows: the run touches nothing and clears the clip flag
		add_dims(5'd0, 5'd1, 5'd1);
		add_op(mma_pkg::OP_RUN, 4'h0, 4'h0, '0, 1'b1, '0, 1'b0);
		add_op(mma_pkg::OP_READ, 4'h0, 4'h0, '0, 1'b1, mma_pkg::ACC_MAX, 1'b0);
		add_op(mma_pkg::OP_LOAD_OUT, 4'hf, 4'hf, 40'h80_0000_0001, 1'b0, '0, 1'b0);
		add_op(mma_pkg::OP_READ, 4'hf, 4'hf, '0, 1'b0, '0, 1'b0);
		add_op(OP_UNUSED_LO, 4'h7, 4'h9, 40'h55_aaaa_5555, 1'b0, '0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].dims_row) begin
				wait_idle();
				set_dims(dir_tab[i].d_rows, dir_tab[i].d_inner, dir_tab[i].d_cols);
			end else begin
				send_item(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);
			end
		end

		// random phases, one dimension setting each; the last runs without idling
		for (int p = 0; p < 9; p++) begin
			wait_idle();
			idle_on = (p != 8);
			set_dims(5'(ph_cfg[p][0]), 5'(ph_cfg[p][1]), 5'(ph_cfg[p][2]));
			fill_region();
			n_items = 30;
			pause_at = $urandom_range(0, n_items - 1);
			for (int n = 0; n < n_items; n++) begin
				if (n == pause_at)
					wait_idle();
				random_item();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (rsp_due.size() != 0) begin
			errors++;
			$display("%0t: responses missing, expected %0d more, actual 0",
				$time, rsp_due.size());
		end

		$display("covered %0d items over %0d dimension settings: %0d runs, %0d of them clipped",
			items_sent, n_settings, n_runs, n_clipped);
		$display("output reads checked: %0d, mismatches: %0d", n_reads, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
